// ----- src/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

	localparam int MAX_PROC = 16;
	localparam int SLOT_W   = $clog2(MAX_PROC);
	localparam int CNT_W    = $clog2(MAX_PROC + 1);
	localparam int TIME_W   = 21;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [15:0]        arrival;
		logic [15:0]        burst;
		logic signed [15:0] prio;
	} req_t;

	typedef struct packed {
		logic [3:0]        run_slot;
		logic              idle;
		logic              switched;
		logic              finished;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] wait_time;
		logic              all_done;
	} res_t;

	// One process table entry as held in the table memory.
	typedef struct packed {
		logic [15:0]        arrival;
		logic [15:0]        burst;
		logic signed [15:0] prio;
		logic [15:0]        rem;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- src/pps_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/preemptive_priority_scheduler_top.sv -----
// A tick scans the loaded table entries, then passes the done state, which registers the result.
// The scan reads one table entry per cycle from the single read port of the table memory; busy
// stays high through the scan and the done state, so no new request is taken until the tick is done.
// Load, clear and unknown requests give no result; busy stays low for them.
// Results are shown for one cycle on valid; the receiver cannot stall.
// Reset clears counts, clock and last slot; the table memory is not cleared.
module preemptive_priority_scheduler_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pps_pkg::req_t request,
	output logic          valid,
	output pps_pkg::res_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [pps_pkg::CNT_W-1:0]   loaded_q;
	logic [pps_pkg::CNT_W-1:0]   done_cnt_q;
	logic [pps_pkg::TIME_W-1:0]  now_q;
	logic [pps_pkg::SLOT_W-1:0]  last_slot_q;
	logic                        last_vld_q;
	logic [pps_pkg::CNT_W-1:0]   idx_q;
	logic                        pend_s1;
	logic [pps_pkg::SLOT_W-1:0]  slot_s1;
	logic                        best_vld_q;
	logic [pps_pkg::SLOT_W-1:0]  best_slot_q;
	pps_pkg::entry_t             best_q;

	logic                        ram_we;
	logic [pps_pkg::SLOT_W-1:0]  ram_waddr;
	pps_pkg::entry_t             ram_wdata;
	logic                        ram_re;
	logic [pps_pkg::ENTRY_W-1:0] ram_rdata;
	pps_pkg::entry_t             rd_entry;

	logic                        accept;
	logic                        full;
	logic                        eligible;
	logic [15:0]                 rem_new;
	logic                        fin;
	logic [pps_pkg::TIME_W-1:0]  now_new;
	logic [pps_pkg::TIME_W-1:0]  ta;
	logic [pps_pkg::TIME_W-1:0]  burst_ext;
	logic [pps_pkg::CNT_W-1:0]   done_new;
	pps_pkg::res_t               res_new;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (loaded_q == pps_pkg::CNT_W'(pps_pkg::MAX_PROC));
	assign rd_entry = pps_pkg::entry_t'(ram_rdata);

	assign ram_re   = (state_q == ST_SCAN) && (idx_q < loaded_q);

	// Table entry under test must have arrived, be unfinished and beat the best so far.
	assign eligible = pend_s1 &&
		({{(pps_pkg::TIME_W - 16){1'b0}}, rd_entry.arrival} <= now_q) &&
		(rd_entry.rem != 16'd0) &&
		(!best_vld_q || (rd_entry.prio > best_q.prio));

	assign rem_new   = best_q.rem - 16'd1;
	assign fin       = best_vld_q && (rem_new == 16'd0);
	assign now_new   = (now_q == pps_pkg::TIME_MAX) ? now_q : now_q + pps_pkg::TIME_W'(1);
	assign ta        = now_new - {{(pps_pkg::TIME_W - 16){1'b0}}, best_q.arrival};
	assign burst_ext = {{(pps_pkg::TIME_W - 16){1'b0}}, best_q.burst};
	assign done_new  = done_cnt_q + (fin ? pps_pkg::CNT_W'(1) : pps_pkg::CNT_W'(0));

	always_comb begin
		res_new          = '0;
		res_new.all_done = (done_new == loaded_q);
		if (!best_vld_q) begin
			res_new.idle = 1'b1;
		end else begin
			res_new.run_slot = 4'(best_slot_q);
			res_new.switched = !last_vld_q || (last_slot_q != best_slot_q);
			res_new.finished = fin;
			if (fin) begin
				res_new.finish_time = now_new;
				res_new.turnaround  = ta;
				res_new.wait_time   = (ta >= burst_ext) ? ta - burst_ext : '0;
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = loaded_q[pps_pkg::SLOT_W-1:0];
		ram_wdata = '{arrival: request.arrival, burst: request.burst,
			prio: request.prio, rem: request.burst};
		if (accept && (request.cmd == pps_pkg::CMD_LOAD) && !full) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_DONE) && best_vld_q) begin
			ram_we    = 1'b1;
			ram_waddr = best_slot_q;
			ram_wdata = best_q;
			ram_wdata.rem = rem_new;
		end
	end

	pps_ram #(
		.WIDTH(pps_pkg::ENTRY_W),
		.DEPTH(pps_pkg::MAX_PROC)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[pps_pkg::SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			done_cnt_q  <= '0;
			now_q       <= '0;
			last_slot_q <= '0;
			last_vld_q  <= 1'b0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			slot_s1     <= '0;
			best_vld_q  <= 1'b0;
			best_slot_q <= '0;
			best_q      <= '0;
			valid       <= 1'b0;
			result      <= '0;
		end else begin
			valid <= (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.cmd)
							pps_pkg::CMD_LOAD: begin
								if (!full) begin
									loaded_q <= loaded_q + pps_pkg::CNT_W'(1);
									if (request.burst == 16'd0) begin
										done_cnt_q <= done_cnt_q + pps_pkg::CNT_W'(1);
									end
								end
							end
							pps_pkg::CMD_TICK: begin
								state_q    <= ST_SCAN;
								idx_q      <= '0;
								pend_s1    <= 1'b0;
								best_vld_q <= 1'b0;
							end
							pps_pkg::CMD_CLEAR: begin
								loaded_q   <= '0;
								done_cnt_q <= '0;
								now_q      <= '0;
								last_vld_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					pend_s1 <= ram_re;
					slot_s1 <= idx_q[pps_pkg::SLOT_W-1:0];
					if (ram_re) begin
						idx_q <= idx_q + pps_pkg::CNT_W'(1);
					end else if (!pend_s1) begin
						state_q <= ST_DONE;
					end
					if (eligible) begin
						best_vld_q  <= 1'b1;
						best_slot_q <= slot_s1;
						best_q      <= rd_entry;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					now_q   <= now_new;
					result  <= res_new;
					if (best_vld_q) begin
						last_slot_q <= best_slot_q;
						last_vld_q  <= 1'b1;
						done_cnt_q  <= done_new;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/pps_checker.sv -----
// Port-level checker for the scheduler top level, with its bind statement.
module pps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input pps_pkg::req_t request,
	input logic          valid,
	input pps_pkg::res_t result
);

	// A result is only shown once the tick has left the busy phase.
	assert property (@(posedge clk) disable iff (!arst_n) valid |-> !busy)
		else $error("result shown while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (request.cmd == pps_pkg::CMD_TICK) |=> busy)
		else $error("tick request did not make the block busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.idle |-> (result.run_slot == 4'd0) && !result.switched &&
		!result.finished)
		else $error("idle tick reports a run");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.finished |-> (result.finish_time == '0) &&
		(result.turnaround == '0) && (result.wait_time == '0))
		else $error("times reported without completion");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && result.finished |-> (result.wait_time <= result.turnaround) &&
		(result.turnaround <= result.finish_time))
		else $error("completion times out of order");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (.*);

// ----- verif/pps_checker.sv -----
// Checker for the priority scheduler: predicts each tick result and compares it with the block.
`timescale 1ns / 100ps
module pps_scoreboard
	import pps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t request,
	input  logic valid,
	input  res_t result,
	output int   errors,
	output int   outstanding,
	output int   results_seen,
	output int   completions_seen
);

	logic [15:0]        arr_tbl [MAX_PROC];
	logic [15:0]        bst_tbl [MAX_PROC];
	logic signed [15:0] pri_tbl [MAX_PROC];
	logic [15:0]        rem_tbl [MAX_PROC];
	int                 n_loaded;
	int                 n_done;
	int                 prev_slot;
	logic [TIME_W-1:0]  now_t;
	res_t               due_results [$];

	function automatic void wipe_schedule();
		n_loaded  = 0;
		n_done    = 0;
		now_t     = '0;
		prev_slot = MAX_PROC;
	endfunction

	function automatic void store_process(input req_t r);
		if (n_loaded < MAX_PROC) begin
			arr_tbl[n_loaded] = r.arrival;
			bst_tbl[n_loaded] = r.burst;
			rem_tbl[n_loaded] = r.burst;
			pri_tbl[n_loaded] = r.prio;
			// A process with nothing to run is complete as soon as it is loaded.
			if (r.burst == '0)
				n_done++;
			n_loaded++;
		end
	endfunction

	function automatic res_t schedule_tick();
		res_t               r;
		int                 pick;
		logic signed [15:0] top_prio;
		logic [TIME_W-1:0]  ta;
		r        = '0;
		pick     = MAX_PROC;
		top_prio = '0;
		for (int i = 0; i < n_loaded; i++) begin
			if (TIME_W'(arr_tbl[i]) <= now_t && rem_tbl[i] != '0 &&
			    (pick == MAX_PROC || pri_tbl[i] > top_prio)) begin
				pick     = i;
				top_prio = pri_tbl[i];
			end
		end
		if (now_t != TIME_MAX)
			now_t++;
		if (pick == MAX_PROC) begin
			r.idle = 1'b1;
		end else begin
			r.run_slot   = pick[3:0];
			r.switched   = (pick != prev_slot);
			prev_slot    = pick;
			rem_tbl[pick] = rem_tbl[pick] - 16'd1;
			if (rem_tbl[pick] == '0) begin
				n_done++;
				ta            = now_t - TIME_W'(arr_tbl[pick]);
				r.finished    = 1'b1;
				r.finish_time = now_t;
				r.turnaround  = ta;
				r.wait_time   = (ta >= TIME_W'(bst_tbl[pick])) ? ta - TIME_W'(bst_tbl[pick]) : '0;
			end
		end
		r.all_done = (n_done == n_loaded);
		return r;
	endfunction

	function automatic void check_field(input string tag, input logic [TIME_W-1:0] want,
	                                    input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, tag, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			wipe_schedule();
			due_results.delete();
			errors           = 0;
			results_seen     = 0;
			completions_seen = 0;
			outstanding      <= 0;
		end else begin
			// Results are compared before a request taken on the same edge is predicted.
			if (valid) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$display("%0t: result expected none, got %h", $time, result);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("run_slot", TIME_W'(want.run_slot), TIME_W'(result.run_slot));
					check_field("idle", TIME_W'(want.idle), TIME_W'(result.idle));
					check_field("switched", TIME_W'(want.switched), TIME_W'(result.switched));
					check_field("finished", TIME_W'(want.finished), TIME_W'(result.finished));
					check_field("finish_time", want.finish_time, result.finish_time);
					check_field("turnaround", want.turnaround, result.turnaround);
					check_field("wait_time", want.wait_time, result.wait_time);
					check_field("all_done", TIME_W'(want.all_done), TIME_W'(result.all_done));
					if (want.finished)
						completions_seen++;
				end
			end
			if (start && !busy) begin
				case (request.cmd)
					CMD_LOAD: begin
						store_process(request);
					end
					CMD_TICK: begin
						due_results = {due_results, schedule_tick()};
					end
					CMD_CLEAR: begin
						wipe_schedule();
					end
					default: begin
					end
				endcase
			end
			outstanding <= due_results.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top: drives scheduler requests, bounds the run time and reports the verdict.
`timescale 1ns / 100ps
module tb_top;
	import pps_pkg::*;

	localparam int LIMIT       = 400000;
	localparam int RANDOM_REQS = 850;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic valid;
	req_t request;
	res_t result;
	int   errors;
	int   outstanding;
	int   results_seen;
	int   completions_seen;
	int   cycles;
	int   idle_pct;
	int   since_clear;
	int   n_sent;
	int   n_loads;
	int   n_ticks;
	int   n_clears;
	int   n_unknown;

	preemptive_priority_scheduler_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.valid   (valid),
		.result  (result)
	);

	pps_scoreboard u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.request          (request),
		.valid            (valid),
		.result           (result),
		.errors           (errors),
		.outstanding      (outstanding),
		.results_seen     (results_seen),
		.completions_seen (completions_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_req(input cmd_t c, input logic [15:0] a, input logic [15:0] b,
	                        input logic [15:0] p);
		req_t r;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		r.cmd     = c;
		r.arrival = a;
		r.burst   = b;
		r.prio    = p;
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		n_sent++;
		case (c)
			CMD_LOAD: begin
				n_loads++;
			end
			CMD_TICK: begin
				n_ticks++;
				since_clear++;
			end
			CMD_CLEAR: begin
				n_clears++;
				since_clear = 0;
			end
			default: begin
				n_unknown++;
			end
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic logic [15:0] pick_arrival();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return 16'($urandom_range(0, since_clear + 4));
		else if (roll < 80)
			return 16'($urandom_range(65535));
		return '0;
	endfunction

	function automatic logic [15:0] pick_burst();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return '0;
		else if (roll < 13)
			return 16'($urandom_range(65535));
		return 16'($urandom_range(1, 6));
	endfunction

	function automatic logic [15:0] pick_prio();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 16'($urandom_range(0, 7));
		else if (roll < 80)
			return 16'($urandom_range(65535));
		return 16'($signed($urandom_range(0, 7)) - 4);
	endfunction

	task automatic send_noise();
		send_req(cmd_t'($urandom_range(3)), 16'($urandom_range(65535)),
		         16'($urandom_range(65535)), 16'($urandom_range(65535)));
	endtask

	// One workload: noise, or optional clear, loads, then ticks with the odd late arrival.
	task automatic run_scenario();
		int          k;
		int          total;
		int          nt;
		int          roll;
		logic [15:0] b;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 6)) send_noise();
		end else begin
			if ($urandom_range(3) != 0)
				send_req(CMD_CLEAR, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
				         16'($urandom_range(65535)));
			k     = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
			total = 0;
			for (int i = 0; i < k; i++) begin
				b = pick_burst();
				total += b;
				send_req(CMD_LOAD, pick_arrival(), b, pick_prio());
			end
			nt = total + $urandom_range(0, 3);
			if (nt > 40)
				nt = 40;
			for (int i = 0; i < nt; i++) begin
				roll = $urandom_range(99);
				if (roll < 5)
					send_req(CMD_LOAD, 16'(since_clear + $urandom_range(0, 3)),
					         16'($urandom_range(1, 4)), pick_prio());
				else if (roll < 8)
					send_req(CMD_NONE, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
					         16'($urandom_range(65535)));
				else
					send_req(CMD_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
					         16'($urandom_range(65535)));
			end
		end
	endtask

	task automatic directed();
		send_req(CMD_TICK, 16'h1234, 16'hABCD, 16'h5A5A);
		send_req(CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_req(CMD_LOAD, 16'd0, 16'd0, 16'd0);
		// Equal lowest priorities: the lower slot must win; the late top priority preempts it.
		send_req(CMD_LOAD, 16'd0, 16'd3, 16'h8000);
		send_req(CMD_LOAD, 16'd0, 16'd1, 16'h8000);
		send_req(CMD_LOAD, 16'd1, 16'd1, 16'h7FFF);
		send_req(CMD_LOAD, 16'hFFFF, 16'hFFFF, 16'h7FFF);
		repeat (6) send_req(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
		send_req(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_req(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
		send_req(CMD_LOAD, 16'd0, 16'd1, 16'd0);
		send_req(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
		send_req(CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
	endtask

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding", cycles, outstanding);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		idle_pct    = 0;
		since_clear = 0;
		n_sent      = 0;
		n_loads     = 0;
		n_ticks     = 0;
		n_clears    = 0;
		n_unknown   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		idle_pct = 21;
		while (n_sent < RANDOM_REQS / 3)
			run_scenario();
		drain();
		idle_pct = 68;
		while (n_sent < 2 * RANDOM_REQS / 3)
			run_scenario();
		drain();
		idle_pct = 0;
		while (n_sent < RANDOM_REQS)
			run_scenario();
		drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d loads, %0d ticks, %0d clears, %0d unknown requests in three pacing mixes.",
		         n_loads, n_ticks, n_clears, n_unknown);
		$display("Checked %0d tick results, %0d of them process completions.",
		         results_seen, completions_seen);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
